### rtl/core/rotation_matrix_to_quaternion_unit_assert.svh
// Assertion macros for the rotation matrix to quaternion unit.
// No dependencies; the macros expand to nothing when NO_ASSERTIONS is defined.
`ifndef ROTATION_MATRIX_TO_QUATERNION_UNIT_ASSERT_SVH
`define ROTATION_MATRIX_TO_QUATERNION_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked out of reset.
`define RMQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked out of reset.
`define RMQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RMQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define RMQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

### rtl/core/rmq_pkg.sv
// Shared types and constants of the rotation matrix to quaternion unit.
// No dependencies.
`timescale 1ns / 1ps
package rmq_pkg;

  localparam int WORD_W        = 16;
  localparam int FRAC_BITS_DEF = 14;

  typedef struct packed {
    logic signed [WORD_W-1:0] c0r0;
    logic signed [WORD_W-1:0] c0r1;
    logic signed [WORD_W-1:0] c0r2;
    logic signed [WORD_W-1:0] c1r0;
    logic signed [WORD_W-1:0] c1r1;
    logic signed [WORD_W-1:0] c1r2;
    logic signed [WORD_W-1:0] c2r0;
    logic signed [WORD_W-1:0] c2r1;
    logic signed [WORD_W-1:0] c2r2;
  } rmq_in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] qx;
    logic signed [WORD_W-1:0] qy;
    logic signed [WORD_W-1:0] qz;
    logic signed [WORD_W-1:0] qw;
    logic                     invalid;
  } rmq_out_t;

  // Output slot that receives s/2
  typedef enum logic [1:0] {
    SLOT_X = 2'd0,
    SLOT_Y = 2'd1,
    SLOT_Z = 2'd2,
    SLOT_W = 2'd3
  } rmq_slot_t;

  // Control carried alongside the arithmetic
  typedef struct packed {
    logic      inv;
    rmq_slot_t hs;
    logic [2:0] neg;
  } rmq_ctl_t;

endpackage

### rtl/core/rmq_sqrt_cell.sv
// One restoring square-root cell: one root bit per cell.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
module rmq_sqrt_cell #(
  parameter int RN     = 16,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              en,
  input  logic [2*RN-1:0]   rad_i,
  input  logic [RN:0]       rem_i,
  input  logic [RN-1:0]     root_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic [2*RN-1:0]   rad_r,
  output logic [RN:0]       rem_r,
  output logic [RN-1:0]     root_r,
  output logic [SIDE_W-1:0] side_r
);

  logic [RN+2:0] cat;
  logic [RN+2:0] trial;
  logic [RN+2:0] diff;
  logic          take;

  // bring down two radicand bits, try (4*root + 1)
  assign cat   = {rem_i, rad_i[2*RN-1 -: 2]};
  assign trial = {1'b0, root_i, 2'b01};
  assign diff  = cat - trial;
  assign take  = (cat >= trial);

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r  <= {rad_i[2*RN-3:0], 2'b00};
      rem_r  <= take ? diff[RN:0] : cat[RN:0];
      root_r <= {root_i[RN-2:0], take};
      side_r <= side_i;
    end
  end

endmodule

### rtl/core/rmq_div_cell.sv
// One restoring division cell for three lanes sharing a divisor: one quotient bit.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
module rmq_div_cell #(
  parameter int NW     = 32,
  parameter int DW     = 17,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              en,
  input  logic [NW-1:0]     num_i  [3],
  input  logic [DW-1:0]     rem_i  [3],
  input  logic [NW-1:0]     quot_i [3],
  input  logic [DW-1:0]     den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic [NW-1:0]     num_r  [3],
  output logic [DW-1:0]     rem_r  [3],
  output logic [NW-1:0]     quot_r [3],
  output logic [DW-1:0]     den_r,
  output logic [SIDE_W-1:0] side_r
);

  logic [DW:0]   cat  [3];
  logic [DW:0]   diff [3];
  logic [2:0]    ge;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      cat[l]  = {rem_i[l], num_i[l][NW-1]};
      diff[l] = cat[l] - {1'b0, den_i};
      ge[l]   = (cat[l] >= {1'b0, den_i});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        num_r[l]  <= {num_i[l][NW-2:0], 1'b0};
        rem_r[l]  <= ge[l] ? diff[l][DW-1:0] : cat[l][DW-1:0];
        quot_r[l] <= {quot_i[l][NW-2:0], ge[l]};
      end
      den_r  <= den_i;
      side_r <= side_i;
    end
  end

endmodule

### rtl/core/rmq_front.sv
// Front stage: trace, pivot choice, square-root argument and off-diagonal terms.
// Depends on rmq_pkg.
`timescale 1ns / 1ps
module rmq_front #(
  parameter int FRAC_BITS = 14,
  parameter int AW        = 19,
  parameter int MW        = 17
) (
  input  logic              clk,
  input  logic              en,
  input  rmq_pkg::rmq_in_t  in_data,
  output logic [AW-2:0]     arg_r,
  output logic [MW-1:0]     mag_r [3],
  output rmq_pkg::rmq_ctl_t ctl_r
);

  import rmq_pkg::*;

  localparam logic signed [AW-1:0] ZERO = '0;
  localparam logic signed [AW-1:0] ONE  = {{(AW-1){1'b0}}, 1'b1} << FRAC_BITS;

  logic [WORD_W-1:0]      raw [3][3];
  logic signed [AW-1:0]   e   [3][3];
  logic signed [AW-1:0]   trace;
  logic signed [AW-1:0]   arg;
  logic signed [AW-1:0]   dw  [3];
  logic signed [MW:0]     d   [3];
  logic                   tpos;
  rmq_slot_t              piv;
  rmq_ctl_t               ctl;
  logic [MW-1:0]          mag [3];

  assign raw[0][0] = in_data.c0r0;
  assign raw[0][1] = in_data.c0r1;
  assign raw[0][2] = in_data.c0r2;
  assign raw[1][0] = in_data.c1r0;
  assign raw[1][1] = in_data.c1r1;
  assign raw[1][2] = in_data.c1r2;
  assign raw[2][0] = in_data.c2r0;
  assign raw[2][1] = in_data.c2r1;
  assign raw[2][2] = in_data.c2r2;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        e[c][r] = signed'({{(AW-WORD_W){raw[c][r][WORD_W-1]}}, raw[c][r]});
      end
    end
  end

  always_comb begin
    trace = e[0][0] + e[1][1] + e[2][2];
    tpos  = (trace > ZERO);
    // strict compares: lowest index wins a tie
    piv = SLOT_X;
    if (e[1][1] > e[0][0]) piv = SLOT_Y;
    if (e[2][2] > ((piv == SLOT_Y) ? e[1][1] : e[0][0])) piv = SLOT_Z;
    if (tpos) begin
      arg    = trace + ONE;
      ctl.hs = SLOT_W;
      dw[0]  = e[1][2] - e[2][1];
      dw[1]  = e[2][0] - e[0][2];
      dw[2]  = e[0][1] - e[1][0];
    end else begin
      ctl.hs = piv;
      case (piv)
        SLOT_X: begin
          arg   = e[0][0] - (e[1][1] + e[2][2]) + ONE;
          dw[0] = e[0][1] + e[1][0];
          dw[1] = e[0][2] + e[2][0];
          dw[2] = e[1][2] - e[2][1];
        end
        SLOT_Y: begin
          arg   = e[1][1] - (e[2][2] + e[0][0]) + ONE;
          dw[0] = e[1][0] + e[0][1];
          dw[1] = e[1][2] + e[2][1];
          dw[2] = e[2][0] - e[0][2];
        end
        default: begin
          arg   = e[2][2] - (e[0][0] + e[1][1]) + ONE;
          dw[0] = e[2][0] + e[0][2];
          dw[1] = e[2][1] + e[1][2];
          dw[2] = e[0][1] - e[1][0];
        end
      endcase
    end
    ctl.inv = (arg <= ZERO);
    for (int l = 0; l < 3; l++) begin
      d[l]       = dw[l][MW:0];
      ctl.neg[l] = d[l][MW];
      mag[l]     = d[l][MW] ? MW'(-d[l]) : d[l][MW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      arg_r <= arg[AW-2:0];
      mag_r <= mag;
      ctl_r <= ctl;
    end
  end

endmodule

### rtl/core/rotation_matrix_to_quaternion_unit.sv
// Rotation matrix to quaternion unit (Shepperd selection), fixed point.
// Channels: in_valid / in_stall / in_data carry one 3x3 matrix per request as nine
//   signed Q2.14 elements; out_valid / out_stall / out_data return qx, qy, qz, qw
//   (saturated Q2.14) and the invalid flag. A request moves when valid is high
//   and stall is low.
// Pipeline: one front register, RN square-root cells (RN is the number of root
//   bits), NW division cells (NW is the quotient width; three lanes each) and
//   the output register.
// Throughput: one matrix per cycle while the receiver keeps out_stall low; every
//   cell hands its item to the next one on each advancing cycle.
// Stall: when a result waits in the output register and out_stall is high, the
//   whole chain holds and in_stall rises in the same cycle; it drops as soon as
//   the result is taken.
// Reset: rst_n (synchronous, active low) clears all valid bits; requests in
//   flight are dropped. Data registers are not reset.
// A non-positive square-root argument gives zero components with invalid set.
// Depends on rmq_pkg, rmq_front, rmq_sqrt_cell, rmq_div_cell and the assertion header.
`timescale 1ns / 1ps
`include "rotation_matrix_to_quaternion_unit_assert.svh"
module rotation_matrix_to_quaternion_unit #(
  parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  rmq_pkg::rmq_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output rmq_pkg::rmq_out_t out_data
);

  import rmq_pkg::*;

  localparam int W      = WORD_W;
  // signed width of the square-root argument
  localparam int AW     = ((W > FRAC_BITS) ? W : FRAC_BITS) + 3;
  localparam int RW0    = AW - 1 + FRAC_BITS;
  localparam int RN     = (RW0 + 1) / 2;
  localparam int RW     = 2 * RN;
  localparam int MW     = W + 1;
  localparam int NW     = (((MW + FRAC_BITS) > RN) ? (MW + FRAC_BITS) : RN) + 1;
  localparam int DW     = RN + 1;
  localparam int CTL_W  = $bits(rmq_ctl_t);
  localparam int SQ_SW  = 3 * MW + CTL_W;
  localparam int DV_SW  = RN + CTL_W;
  localparam int NSTG   = 1 + RN + NW;
  localparam int CW     = ((NW > RN) ? NW : RN) + 1;
  localparam logic [CW-1:0] SMAX_C = CW'((64'd1 << (W - 1)) - 64'd1);
  localparam logic [CW-1:0] SMIN_M = CW'(64'd1 << (W - 1));

  logic              adv;
  logic [NSTG-1:0]   vld_r;
  logic [NSTG-1:0]   vld_nxt;
  logic              out_valid_r;
  rmq_out_t          out_data_r;
  rmq_out_t          out_data_nxt;

  // front stage
  logic [AW-2:0]     arg_f;
  logic [MW-1:0]     mag_f [3];
  rmq_ctl_t          ctl_f;

  // square-root chain
  logic [RW-1:0]     s_rad  [RN+1];
  logic [RN:0]       s_rem  [RN+1];
  logic [RN-1:0]     s_root [RN+1];
  logic [SQ_SW-1:0]  s_side [RN+1];

  // division chain
  logic [NW-1:0]     d_num  [NW+1][3];
  logic [DW-1:0]     d_rem  [NW+1][3];
  logic [NW-1:0]     d_quot [NW+1][3];
  logic [DW-1:0]     d_den  [NW+1];
  logic [DV_SW-1:0]  d_side [NW+1];

  logic [MW-1:0]     sq_mag [3];
  rmq_ctl_t          sq_ctl;
  rmq_ctl_t          dv_ctl;
  logic [RN-1:0]     dv_s;
  logic [W-1:0]      lane_q [3];
  logic [W-1:0]      half_q;
  logic [W-1:0]      slot_q [4];

  // advance everything unless a finished result is held by the receiver
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  assign vld_nxt = {vld_r[NSTG-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= vld_nxt;
      out_valid_r <= vld_r[NSTG-1];
    end
  end

  rmq_front #(
    .FRAC_BITS (FRAC_BITS),
    .AW        (AW),
    .MW        (MW)
  ) u_front (
    .clk     (clk),
    .en      (adv),
    .in_data (in_data),
    .arg_r   (arg_f),
    .mag_r   (mag_f),
    .ctl_r   (ctl_f)
  );

  // radicand is arg scaled up by FRAC_BITS
  assign s_rad[0]  = RW'({arg_f, {FRAC_BITS{1'b0}}});
  assign s_rem[0]  = '0;
  assign s_root[0] = '0;
  assign s_side[0] = {mag_f[0], mag_f[1], mag_f[2], ctl_f};

  for (genvar g = 0; g < RN; g++) begin : g_sqrt
    rmq_sqrt_cell #(
      .RN     (RN),
      .SIDE_W (SQ_SW)
    ) u_cell (
      .clk    (clk),
      .en     (adv),
      .rad_i  (s_rad[g]),
      .rem_i  (s_rem[g]),
      .root_i (s_root[g]),
      .side_i (s_side[g]),
      .rad_r  (s_rad[g+1]),
      .rem_r  (s_rem[g+1]),
      .root_r (s_root[g+1]),
      .side_r (s_side[g+1])
    );
  end

  assign {sq_mag[0], sq_mag[1], sq_mag[2], sq_ctl} = s_side[RN];

  // numerator |d| * 2^F + s over divisor 2s: rounds half away from zero
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      d_num[0][l]  = NW'({sq_mag[l], {FRAC_BITS{1'b0}}}) + NW'(s_root[RN]);
      d_rem[0][l]  = '0;
      d_quot[0][l] = '0;
    end
  end
  assign d_den[0]  = {s_root[RN], 1'b0};
  assign d_side[0] = {s_root[RN], sq_ctl};

  for (genvar g = 0; g < NW; g++) begin : g_div
    rmq_div_cell #(
      .NW     (NW),
      .DW     (DW),
      .SIDE_W (DV_SW)
    ) u_cell (
      .clk    (clk),
      .en     (adv),
      .num_i  (d_num[g]),
      .rem_i  (d_rem[g]),
      .quot_i (d_quot[g]),
      .den_i  (d_den[g]),
      .side_i (d_side[g]),
      .num_r  (d_num[g+1]),
      .rem_r  (d_rem[g+1]),
      .quot_r (d_quot[g+1]),
      .den_r  (d_den[g+1]),
      .side_r (d_side[g+1])
    );
  end

  assign {dv_s, dv_ctl} = d_side[NW];

  // apply sign and saturate; place s/2 in its slot, the lanes around it
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (dv_ctl.neg[l]) begin
        lane_q[l] = (CW'(d_quot[NW][l]) > SMIN_M) ? SMIN_M[W-1:0]
                                                  : W'(-d_quot[NW][l][W-1:0]);
      end else begin
        lane_q[l] = (CW'(d_quot[NW][l]) > SMAX_C) ? SMAX_C[W-1:0]
                                                  : d_quot[NW][l][W-1:0];
      end
    end
    half_q = (CW'(dv_s >> 1) > SMAX_C) ? SMAX_C[W-1:0] : W'(dv_s >> 1);
    case (dv_ctl.hs)
      SLOT_X: begin
        slot_q = '{half_q, lane_q[0], lane_q[1], lane_q[2]};
      end
      SLOT_Y: begin
        slot_q = '{lane_q[0], half_q, lane_q[1], lane_q[2]};
      end
      SLOT_Z: begin
        slot_q = '{lane_q[0], lane_q[1], half_q, lane_q[2]};
      end
      default: begin
        slot_q = '{lane_q[0], lane_q[1], lane_q[2], half_q};
      end
    endcase
    if (dv_ctl.inv) begin
      out_data_nxt = '0;
      out_data_nxt.invalid = 1'b1;
    end else begin
      out_data_nxt.qx      = slot_q[0];
      out_data_nxt.qy      = slot_q[1];
      out_data_nxt.qz      = slot_q[2];
      out_data_nxt.qw      = slot_q[3];
      out_data_nxt.invalid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `RMQ_ASSERT_IMP(a_inv_zero, clk, rst_n, out_valid_r && out_data_r.invalid,
    (out_data_r.qx == '0) && (out_data_r.qy == '0) && (out_data_r.qz == '0) &&
    (out_data_r.qw == '0), "invalid result carries non-zero components")
  `RMQ_ASSERT_IMP(a_stall_src, clk, rst_n, in_stall, out_valid_r && out_stall,
    "input stalled without a held result")
  `RMQ_ASSERT_NXT(a_hold_chain, clk, rst_n, !adv, $stable(vld_r) && out_valid_r,
    "chain moved while the result was held")

endmodule

### tb/sv/tb_top.sv
// Self-checking bench for rotation_matrix_to_quaternion_unit: random and directed matrices.
// Expected quaternions come from a fixed-point predictor in this file; depends on rmq_pkg.
`timescale 1ns / 1ps
module tb_top;
  import rmq_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam int N_RANDOM = 900;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 80;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  rmq_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  rmq_out_t out_data;

  rmq_in_t  pending_mats[$];
  rmq_out_t expected_quats[$];
  int       n_errors = 0;
  int       n_sent = 0;
  int       n_recv = 0;
  int       n_invalid = 0;
  int       idle_cycles = 0;
  bit       calm = 1'b0;      // no idling in the last part of the run
  bit       hold_sender = 1'b0;
  int       send_gap = 0;
  int       recv_gap = 0;

  always #10 clk = ~clk;

  rotation_matrix_to_quaternion_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  function automatic longint unsigned root_floor(longint unsigned a);
    longint unsigned r = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > a) b >>= 2;
    while (b != 0) begin
      if (a >= r + b) begin
        a -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // d * 0.5 / s, rounded half away from zero
  function automatic longint half_over_root(longint d, longint unsigned s);
    longint unsigned mag = (d < 0) ? longint'(-d) : d;
    longint q = longint'(((mag << FB) + s) / (2 * s));
    return (d < 0) ? -q : q;
  endfunction

  function automatic logic signed [WORD_W-1:0] clamp_word(longint v);
    longint hi = (longint'(1) << (WORD_W - 1)) - 1;
    if (v > hi) return WORD_W'(hi);
    if (v < -hi - 1) return WORD_W'(-hi - 1);
    return WORD_W'(v);
  endfunction

  function automatic rmq_out_t quat_of_matrix(rmq_in_t m);
    longint e[3][3];
    longint q[4];
    longint tr, a;
    longint unsigned s;
    int i, j, k;
    rmq_out_t o;
    e[0][0] = longint'(m.c0r0); e[0][1] = longint'(m.c0r1); e[0][2] = longint'(m.c0r2);
    e[1][0] = longint'(m.c1r0); e[1][1] = longint'(m.c1r1); e[1][2] = longint'(m.c1r2);
    e[2][0] = longint'(m.c2r0); e[2][1] = longint'(m.c2r1); e[2][2] = longint'(m.c2r2);
    tr = e[0][0] + e[1][1] + e[2][2];
    i = 0;
    if (tr > 0) begin
      a = tr + (longint'(1) << FB);
    end else begin
      if (e[1][1] > e[0][0]) i = 1;
      if (e[2][2] > e[i][i]) i = 2;
      j = (i + 1) % 3;
      k = (j + 1) % 3;
      a = e[i][i] - (e[j][j] + e[k][k]) + (longint'(1) << FB);
    end
    o = '0;
    if (a <= 0) begin
      o.invalid = 1'b1;
      return o;
    end
    s = root_floor(longint'(a) << FB);
    if (tr > 0) begin
      q[0] = half_over_root(e[1][2] - e[2][1], s);
      q[1] = half_over_root(e[2][0] - e[0][2], s);
      q[2] = half_over_root(e[0][1] - e[1][0], s);
      q[3] = s >> 1;
    end else begin
      j = (i + 1) % 3;
      k = (j + 1) % 3;
      q[i] = s >> 1;
      q[3] = half_over_root(e[j][k] - e[k][j], s);
      q[j] = half_over_root(e[i][j] + e[j][i], s);
      q[k] = half_over_root(e[i][k] + e[k][i], s);
    end
    o.qx = clamp_word(q[0]);
    o.qy = clamp_word(q[1]);
    o.qz = clamp_word(q[2]);
    o.qw = clamp_word(q[3]);
    return o;
  endfunction

  function automatic rmq_in_t diag_matrix(int d0, int d1, int d2, int off);
    rmq_in_t m;
    m = '{default: WORD_W'(off)};
    m.c0r0 = WORD_W'(d0); m.c1r1 = WORD_W'(d1); m.c2r2 = WORD_W'(d2);
    return m;
  endfunction

  // Random proper rotation-ish matrix: near-orthonormal pattern with noise,
  // or a fully random word set.
  function automatic rmq_in_t random_matrix();
    rmq_in_t m;
    int unsigned mode = $urandom_range(0, 9);
    logic [WORD_W-1:0] w[9];
    for (int n = 0; n < 9; n++) begin
      case (mode)
        0, 1, 2: w[n] = WORD_W'($urandom);                          // any word
        3, 4:    w[n] = WORD_W'($urandom_range(0, 32767) - 16384);  // |x| <= 1.0
        default: w[n] = WORD_W'($urandom_range(0, 4000) - 2000);    // small off-diagonals
      endcase
    end
    if (mode >= 5) begin
      // strong diagonal, sign pattern chosen so every branch is reached
      for (int n = 0; n < 9; n += 4)
        w[n] = WORD_W'(($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(8000, 16384)));
    end
    {m.c0r0, m.c0r1, m.c0r2, m.c1r0, m.c1r1, m.c1r2, m.c2r0, m.c2r1, m.c2r2} =
      {w[0], w[1], w[2], w[3], w[4], w[5], w[6], w[7], w[8]};
    return m;
  endfunction

  // Driver: hold the request until it is taken, advance on acceptance.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_quats.push_back(quat_of_matrix(in_data));
        n_sent <= n_sent + 1;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_mats.size() > 0 && !hold_sender) begin
          in_valid <= 1'b1;
          in_data <= pending_mats.pop_front();
          if (!calm && $urandom_range(0, 19) == 0) send_gap <= $urandom_range(1, 15);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted quaternion with the oldest prediction.
  always @(posedge clk) begin
    rmq_out_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        n_recv <= n_recv + 1;
        if (expected_quats.size() == 0) begin
          $error("quaternion with no matrix outstanding: %h", out_data);
          n_errors++;
        end else begin
          want = expected_quats.pop_front();
          if (out_data.invalid) n_invalid <= n_invalid + 1;
          if (out_data.qx !== want.qx) begin
            $error("qx expected %0d actual %0d", want.qx, out_data.qx);
            n_errors++;
          end
          if (out_data.qy !== want.qy) begin
            $error("qy expected %0d actual %0d", want.qy, out_data.qy);
            n_errors++;
          end
          if (out_data.qz !== want.qz) begin
            $error("qz expected %0d actual %0d", want.qz, out_data.qz);
            n_errors++;
          end
          if (out_data.qw !== want.qw) begin
            $error("qw expected %0d actual %0d", want.qw, out_data.qw);
            n_errors++;
          end
          if (out_data.invalid !== want.invalid) begin
            $error("invalid expected %0b actual %0b", want.invalid, out_data.invalid);
            n_errors++;
          end
        end
      end
      // receiver stalls in bursts
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 24) == 0) begin
        recv_gap <= $urandom_range(0, 14);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: count cycles with no request moving on either channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", expected_quats.size());
      $display("FAIL rotation_matrix_to_quaternion_unit");
      $finish;
    end
  end

  initial begin
    // Directed: identity, half-turns about each axis, ties, extremes.
    pending_mats.push_back(diag_matrix(16384, 16384, 16384, 0));
    pending_mats.push_back(diag_matrix(16384, -16384, -16384, 0));
    pending_mats.push_back(diag_matrix(-16384, 16384, -16384, 0));
    pending_mats.push_back(diag_matrix(-16384, -16384, 16384, 0));
    pending_mats.push_back(diag_matrix(-16384, -16384, -16384, 0));   // equal diagonal tie
    pending_mats.push_back(diag_matrix(0, 0, 0, 0));                  // tie at zero trace
    pending_mats.push_back(diag_matrix(-5000, -3000, -3000, 1234));   // tie between 1 and 2
    pending_mats.push_back(diag_matrix(-32768, -32768, -32768, 0));   // all-negative diagonal at full scale
    pending_mats.push_back(diag_matrix(-8192, -8192, -8192, 0));      // all-negative diagonal at half scale
    pending_mats.push_back(diag_matrix(32767, 32767, 32767, 32767));
    pending_mats.push_back(diag_matrix(32767, 32767, 32767, -32768));
    pending_mats.push_back(diag_matrix(-32768, 32767, -32768, 32767));
    pending_mats.push_back(diag_matrix(-32768, -32768, 32767, -32768));
    pending_mats.push_back(diag_matrix(32767, -32768, -32768, -1));
    pending_mats.push_back(diag_matrix(1, -1, 0, 32767));             // zero trace
    pending_mats.push_back('1);
    pending_mats.push_back('0);
    for (int n = 0; n < N_RANDOM / 2; n++) pending_mats.push_back(random_matrix());

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Hold the sender once until the pipeline has drained completely.
    wait (pending_mats.size() < N_RANDOM / 4);
    hold_sender = 1'b1;
    wait (!in_valid && expected_quats.size() == 0);
    hold_sender = 1'b0;
    for (int n = 0; n < N_RANDOM / 2; n++) pending_mats.push_back(random_matrix());
    wait (pending_mats.size() < 100);
    calm = 1'b1;
    wait (pending_mats.size() == 0 && !in_valid && expected_quats.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d matrices, checked %0d quaternions (%0d with invalid root)",
             n_sent, n_recv, n_invalid);
    if (n_errors == 0 && expected_quats.size() == 0) begin
      $display("PASS rotation_matrix_to_quaternion_unit");
    end else begin
      $display("FAIL rotation_matrix_to_quaternion_unit");
    end
    $finish;
  end
endmodule

### filelist.f
+incdir+rtl/core
rtl/core/rmq_pkg.sv
rtl/core/rmq_sqrt_cell.sv
rtl/core/rmq_div_cell.sv
rtl/core/rmq_front.sv
rtl/core/rotation_matrix_to_quaternion_unit.sv
tb/sv/tb_top.sv
